@@ hw/rtl/daq_event_deframe_filter_assert.svh @@
// Assertion macros for the event deframer and filter
`ifndef DAQ_EVENT_DEFRAME_FILTER_ASSERT_SVH
`define DAQ_EVENT_DEFRAME_FILTER_ASSERT_SVH

`ifndef SYNTH

`define DAQEDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("daq_event_deframe_filter: assertion failed");

`define DAQEDF_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("daq_event_deframe_filter: forbidden condition seen");

`else

`define DAQEDF_ASSERT(lbl, clk, rst_n, prop)

`define DAQEDF_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/daqedf_pkg.sv @@
`default_nettype none

package daqedf_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_PAYLOAD
  } phase_t;

  localparam logic [31:0] SYNC_V1 = 32'hbeef2021;
  localparam logic [31:0] SYNC_V2 = 32'hbeef2022;

  localparam logic [3:0] VER_ONE = 4'd1;
  localparam logic [3:0] VER_TWO = 4'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_V1_UNSUP  = 2'd1;
  localparam logic [1:0] ST_BAD_VER   = 2'd2;

  localparam logic [4:0] IDX_HEADER  = 5'd1;
  localparam logic [4:0] IDX_SAMPLE0 = 5'd2;
  localparam logic [4:0] IDX_SPILL   = 5'd10;
  localparam logic [4:0] IDX_TICK    = 5'd11;
  localparam logic [4:0] IDX_RUN     = 5'd13;

  localparam logic [16:0] LEFT_HEAD = 17'd13;

  localparam logic [1:0] REG_SKIP    = 2'd0;
  localparam logic [1:0] REG_TICK_LO = 2'd1;
  localparam logic [1:0] REG_TICK_HI = 2'd2;

  localparam logic [31:0] TICK_HI_RST = 32'hffffffff;

  typedef struct packed {
    logic [15:0] spill_skip;
    logic [31:0] tick_lo;
    logic [31:0] tick_hi;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] data_word;
    logic        first_of_event;
    logic        last_of_event;
    logic        keep_event;
    logic [63:0] timestamp;
    logic [11:0] spill_number;
    logic [31:0] tick_count;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/daqedf_core.sv @@
`default_nettype none

module daqedf_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [31:0]       word,
  input  wire daqedf_pkg::cfg_t  cfg,
  output daqedf_pkg::res_t       res
);
  import daqedf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [16:0] left_r, left_nxt;
  logic [11:0] ev_spill_r, ev_spill_nxt;
  logic [31:0] ev_ticks_r, ev_ticks_nxt;
  logic [11:0] prev_spill_r, prev_spill_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [15:0] skips_r, skips_nxt;
  logic [31:0] kept_r, kept_nxt;
  logic        keeping_r, keeping_nxt;

  logic        is_sync;
  logic [3:0]  version;
  logic        hdr_bad;
  logic        fin;
  logic        in_win;
  logic        new_spill;
  logic        skipping;
  logic        keep;
  logic [31:0] kept_inc;
  logic [31:0] kept_eff;

  assign is_sync = (word == SYNC_V1) || (word == SYNC_V2);
  assign version = word[31:28];

  assign hdr_bad = (phase_r == PH_HEAD) && (idx_r == IDX_HEADER) && (version != VER_TWO);
  assign fin = ((phase_r == PH_HEAD) && (idx_r == IDX_RUN) && (left_r <= LEFT_HEAD)) ||
               ((phase_r == PH_PAYLOAD) && (left_r <= 17'd1));

  assign in_win    = (ev_ticks_r >= cfg.tick_lo) && (ev_ticks_r <= cfg.tick_hi);
  assign new_spill = !prev_valid_r || (ev_spill_r != prev_spill_r);
  assign skipping  = skips_r < cfg.spill_skip;
  assign kept_inc  = kept_r + 32'd1;
  assign keep      = in_win && (new_spill ? !skipping : keeping_r);
  assign kept_eff  = (in_win && new_spill && !skipping) ? kept_inc : kept_r;

  always_comb begin
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    ev_spill_nxt   = ev_spill_r;
    ev_ticks_nxt   = ev_ticks_r;
    prev_spill_nxt = prev_spill_r;
    prev_valid_nxt = prev_valid_r;
    skips_nxt      = skips_r;
    kept_nxt       = kept_r;
    keeping_nxt    = keeping_r;
    if (step) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (is_sync) begin
            phase_nxt = PH_HEAD;
            idx_nxt   = IDX_HEADER;
          end
        end
        PH_HEAD: begin
          if (idx_r == IDX_HEADER) begin
            if (version == VER_TWO) begin
              left_nxt = {word[15:0], 1'b0} - 17'd1;
              idx_nxt  = IDX_SAMPLE0;
            end else begin
              phase_nxt = PH_HUNT;
              idx_nxt   = '0;
              left_nxt  = '0;
            end
          end else begin
            if (idx_r == IDX_SPILL) ev_spill_nxt = word[23:12];
            if (idx_r == IDX_TICK) ev_ticks_nxt = word;
            if (idx_r == IDX_RUN) begin
              if (fin) begin
                phase_nxt = PH_HUNT;
                idx_nxt   = '0;
                left_nxt  = '0;
              end else begin
                left_nxt  = left_r - LEFT_HEAD;
                phase_nxt = PH_PAYLOAD;
                idx_nxt   = '0;
              end
            end else begin
              idx_nxt = idx_r + 5'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (fin) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            left_nxt  = '0;
          end else begin
            left_nxt = left_r - 17'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
      if (fin && in_win && new_spill) begin
        prev_spill_nxt = ev_spill_r;
        prev_valid_nxt = 1'b1;
        if (skipping) begin
          skips_nxt   = skips_r + 16'd1;
          keeping_nxt = 1'b0;
        end else begin
          keeping_nxt = 1'b1;
          kept_nxt    = kept_inc;
        end
      end
    end
  end

  always_comb begin
    res                = '0;
    res.valid          = (phase_r != PH_HUNT) || is_sync;
    res.data_word      = word;
    res.first_of_event = (phase_r == PH_HUNT);
    res.last_of_event  = fin || hdr_bad;
    if (fin) begin
      res.keep_event   = keep;
      res.timestamp    = keep ? {kept_eff, ev_ticks_r} : 64'd0;
      res.spill_number = ev_spill_r;
      res.tick_count   = ev_ticks_r;
    end
    if (hdr_bad) begin
      res.status = (version == VER_ONE) ? ST_V1_UNSUP : ST_BAD_VER;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      idx_r        <= '0;
      left_r       <= '0;
      ev_spill_r   <= '0;
      ev_ticks_r   <= '0;
      prev_spill_r <= '0;
      prev_valid_r <= 1'b0;
      skips_r      <= '0;
      kept_r       <= '0;
      keeping_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      left_r       <= left_nxt;
      ev_spill_r   <= ev_spill_nxt;
      ev_ticks_r   <= ev_ticks_nxt;
      prev_spill_r <= prev_spill_nxt;
      prev_valid_r <= prev_valid_nxt;
      skips_r      <= skips_nxt;
      kept_r       <= kept_nxt;
      keeping_r    <= keeping_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/daq_event_deframe_filter.sv @@
// A transferred word is held in the input register, and its result in the result register.
// Throughput: one word per cycle; the input register and the result register
// let a new word in while a result waits, a stall of the result side holds both.
// Words dropped while hunting for sync produce no result.
// Reset (synchronous, active low) clears framing state, spill counters, and
// restores the registers to their defaults (upper tick bound all ones).
`default_nettype none

`include "daq_event_deframe_filter_assert.svh"

module daq_event_deframe_filter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // word[31:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // data_word[31:0], timestamp[95:32], spill_number[107:96],
  // tick_count[139:108], zero[143:140]
  output logic [143:0]      out_tdata,
  output logic              out_tlast,  // last_of_event
  output logic [3:0]        out_tuser,  // first_of_event[0], keep_event[1], status[3:2]
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import daqedf_pkg::*;

  cfg_t        cfg_r;
  logic        cfg_wr;

  logic        in_valid_r;
  logic [31:0] in_word_r;
  logic        advance;
  logic        step;
  res_t        res;

  logic        out_valid_r;
  res_t        out_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spill_skip <= '0;
      cfg_r.tick_lo    <= '0;
      cfg_r.tick_hi    <= TICK_HI_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SKIP:    cfg_r.spill_skip <= cfg_pwdata[15:0];
        REG_TICK_LO: cfg_r.tick_lo    <= cfg_pwdata;
        REG_TICK_HI: cfg_r.tick_hi    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SKIP:    cfg_prdata = {16'd0, cfg_r.spill_skip};
      REG_TICK_LO: cfg_prdata = cfg_r.tick_lo;
      REG_TICK_HI: cfg_prdata = cfg_r.tick_hi;
      default:     cfg_prdata = '0;
    endcase
  end

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_word_r <= in_tdata;
    end
  end

  daqedf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .word  (in_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.tick_count, out_r.spill_number,
                       out_r.timestamp, out_r.data_word};
  assign out_tlast  = out_r.last_of_event;
  assign out_tuser  = {out_r.status, out_r.keep_event, out_r.first_of_event};

  `DAQEDF_ASSERT(a_first_not_last, clk, rst_n,
                 out_valid_r && out_r.first_of_event |-> !out_r.last_of_event)
  `DAQEDF_ASSERT(a_verdict_on_last, clk, rst_n,
                 out_valid_r && (out_r.keep_event || out_r.status != ST_OK)
                 |-> out_r.last_of_event)
  `DAQEDF_ASSERT(a_ts_low_is_ticks, clk, rst_n,
                 out_valid_r && out_r.keep_event
                 |-> out_r.timestamp[31:0] == out_r.tick_count)
  `DAQEDF_NEVER(a_no_result_lost, clk, rst_n,
                out_valid_r && !out_tready && $past(rst_n) &&
                $past(out_valid_r && !out_tready) && !$stable(out_r))

endmodule

`default_nettype wire
